[rtl/tccp_pkg.sv]
// Package: widths, limits and beat types for the task chain critical path block.
package tccp_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TIME_W    = 24;
  localparam int CRIT_W    = 28;

  localparam logic [CRIT_W-1:0] CRIT_MAX = {CRIT_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] task_time;
    logic              has_successor;
    logic [3:0]        successor_index;
    logic              last_task;
  } tccp_in_t;

  typedef struct packed {
    logic [3:0]        task_index;
    logic [CRIT_W-1:0] critical_time;
    logic              graph_error;
    logic              last_result;
  } tccp_out_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
  } tccp_link_t;

endpackage

[rtl/task_chain_critical_path.sv]
// Top level: task chain critical time, loader, chain walker and result emitter.
//
//  Channel  | Signals                        | Beat
//  ---------+--------------------------------+------------------------------------
//  input    | in_valid, in_ready, in_data    | one task: time, successor, last mark
//  output   | out_valid, out_ready, out_data | one critical time per task, in order
//
// Loading takes one beat per cycle. After the last task of a graph of n tasks,
// each chain is walked in turn: a start state loads the head's time, then each of
// at most n-1 links walked adds its time through the single shared saturating adder.
// Results then leave at one per cycle while out_ready is high.
// in_ready is low from the last task beat until the last result is registered.
// Reset (synchronous, rst high) empties the store and drops any pending result.
module task_chain_critical_path
  import tccp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tccp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tccp_out_t out_data
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_START,
    S_WALK,
    S_EMIT
  } state_t;

  // Task stores; only entries of the current graph are ever used.
  logic [TIME_W-1:0] time_store      [MAX_TASKS];
  tccp_link_t        successor_store [MAX_TASKS];
  logic [CRIT_W-1:0] critical_store  [MAX_TASKS];

  state_t            state;
  logic [CNT_W-1:0]  loaded_count;
  logic [IDX_W-1:0]  head_idx;   // task whose chain is being walked
  logic [IDX_W-1:0]  cur;        // current link in that chain
  logic [CNT_W-1:0]  visited;
  logic [CRIT_W-1:0] sum;
  logic              err;
  logic [IDX_W-1:0]  emit_idx;

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  count_next;
  tccp_link_t        link;
  logic [IDX_W-1:0]  time_addr;
  logic [TIME_W-1:0] time_rd;
  logic [CRIT_W-1:0] sum_next;
  logic              bad_link;
  logic              task_is_last;
  logic              emit_is_last;
  logic              out_free;

  assign in_ready   = (state == S_LOAD);
  assign accept     = in_valid && in_ready;
  assign full       = (loaded_count == CNT_W'(MAX_TASKS));
  assign count_next = full ? loaded_count : loaded_count + 1'b1;

  assign link      = successor_store[cur];
  // One time read port: chain head on the start cycle, next link while walking.
  assign time_addr = (state == S_START) ? head_idx : link.index;
  assign time_rd   = time_store[time_addr];
  assign bad_link  = ({1'b0, link.index} >= loaded_count) || (visited >= loaded_count);

  assign task_is_last = ({1'b0, head_idx} + 1'b1) == loaded_count;
  assign emit_is_last = ({1'b0, emit_idx} + 1'b1) == loaded_count;
  assign out_free     = !out_valid || out_ready;

  tccp_sat_add u_sat_add (
    .sum    (sum),
    .addend (time_rd),
    .result (sum_next)
  );

  // Stores: payload only, no reset.
  always_ff @(posedge clk) begin
    if (accept && !full) begin
      time_store[loaded_count[IDX_W-1:0]]            <= in_data.task_time;
      successor_store[loaded_count[IDX_W-1:0]].valid <= in_data.has_successor;
      successor_store[loaded_count[IDX_W-1:0]].index <= in_data.successor_index[IDX_W-1:0];
    end
    if (state == S_WALK && (!link.valid || bad_link)) begin
      critical_store[head_idx] <= sum;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded_count <= '0;
      head_idx     <= '0;
      cur          <= '0;
      visited      <= '0;
      err          <= 1'b0;
      emit_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // Output slot: filled while emitting, emptied once the beat is taken.
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            loaded_count <= count_next;
            if (in_data.last_task) begin
              head_idx <= '0;
              err      <= 1'b0;
              state    <= S_START;
            end
          end
        end
        S_START: begin
          sum     <= {{(CRIT_W - TIME_W){1'b0}}, time_rd};
          cur     <= head_idx;
          visited <= CNT_W'(1);
          state   <= S_WALK;
        end
        S_WALK: begin
          if (!link.valid || bad_link) begin
            // Chain ends here, cleanly or at a fault.
            if (link.valid) begin
              err <= 1'b1;
            end
            if (task_is_last) begin
              emit_idx <= '0;
              state    <= S_EMIT;
            end else begin
              head_idx <= head_idx + 1'b1;
              state    <= S_START;
            end
          end else begin
            sum     <= sum_next;
            cur     <= link.index;
            visited <= visited + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_is_last) begin
              loaded_count <= '0;
              state        <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_data.task_index    <= 4'(emit_idx);
      out_data.critical_time <= critical_store[emit_idx];
      out_data.graph_error   <= err;
      out_data.last_result   <= emit_is_last;
    end
  end

endmodule

[rtl/tccp_sat_add.sv]
// Saturating adder: running chain sum plus one task time.
module tccp_sat_add
  import tccp_pkg::*;
(
  input  logic [CRIT_W-1:0] sum,
  input  logic [TIME_W-1:0] addend,
  output logic [CRIT_W-1:0] result
);

  logic [CRIT_W:0] wide;

  assign wide   = {1'b0, sum} + {{(CRIT_W + 1 - TIME_W){1'b0}}, addend};
  assign result = wide[CRIT_W] ? CRIT_MAX : wide[CRIT_W-1:0];

endmodule

[tb/sv/task_chain_critical_path_tb.sv]
// Testbench for task_chain_critical_path: queued task beats, chain predictor, result checks.
`timescale 1ns / 1ps

module task_chain_critical_path_tb;
  import tccp_pkg::*;

  // Idling percentages per phase: receiver-heavy, sender-heavy, then none at all.
  localparam int SEND_IDLE [3] = '{30, 64, 0};
  localparam int RECV_IDLE [3] = '{64, 30, 0};
  localparam int RANDOM_BEATS  = 295;
  localparam int HOLD_CYCLES   = 400;   // one long output back-pressure stretch
  localparam int DRAIN_CYCLES  = 300;   // longer than the walk of a full graph

  typedef enum int {
    SHAPE_CHAINS,    // forward links only, every walk ends cleanly
    SHAPE_BAD_LINK,  // one link points past the loaded tasks
    SHAPE_LOOP,      // one link points back, so some chain loops
    SHAPE_NOISE      // links entirely random
  } graph_shape_e;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  tccp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tccp_out_t out_data;

  // Stimulus still to be offered, and critical-time results still owed by the block.
  tccp_in_t  task_beats_pending [$];
  tccp_out_t crit_times_due [$];

  // Predictor's own copy of the task store.
  logic [TIME_W-1:0] held_time [MAX_TASKS];
  tccp_link_t        held_link [MAX_TASKS];
  int                tasks_held = 0;

  int total_beats    = 0;
  int beats_accepted = 0;
  int mismatch_count = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  task_chain_critical_path uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling phase follows progress through the stimulus: thirds of the beat count.
  function automatic int idle_phase();
    int p;
    p = (total_beats == 0) ? 0 : (beats_accepted * 3) / total_beats;
    return (p > 2) ? 2 : p;
  endfunction

  // Stores one accepted task beat; on the last mark walks every chain and queues
  // one critical time per held task. A beat arriving with the store full is dropped,
  // but its last mark still closes the graph.
  task automatic predict_critical_times(input tccp_in_t b);
    int              n;
    int              cur;
    int              seen;
    bit              done;
    bit              graph_fault;
    logic [CRIT_W:0] sum;
    tccp_out_t       r;
    logic [CRIT_W-1:0] crit [MAX_TASKS];
    if (tasks_held < MAX_TASKS) begin
      held_time[tasks_held]       = b.task_time;
      held_link[tasks_held].valid = b.has_successor;
      held_link[tasks_held].index = b.successor_index;
      tasks_held++;
    end
    if (!b.last_task) return;
    n = tasks_held;
    graph_fault = 1'b0;
    for (int i = 0; i < n; i++) begin
      cur  = i;
      seen = 1;
      sum  = {1'b0, 4'h0, held_time[i]};
      done = 1'b0;
      while (!done) begin
        if (!held_link[cur].valid) begin
          done = 1'b1;
        end else if (int'(held_link[cur].index) >= n || seen >= n) begin
          // link past the graph, or more steps than tasks: a loop
          graph_fault = 1'b1;
          done        = 1'b1;
        end else begin
          cur = held_link[cur].index;
          sum = sum + held_time[cur];
          if (sum > {1'b0, CRIT_MAX}) sum = {1'b0, CRIT_MAX};
          seen++;
        end
      end
      crit[i] = sum[CRIT_W-1:0];
    end
    for (int i = 0; i < n; i++) begin
      r.task_index    = i[3:0];
      r.critical_time = crit[i];
      r.graph_error   = graph_fault;
      r.last_result   = (i == n - 1);
      crit_times_due.push_back(r);
    end
    tasks_held = 0;
  endtask

  // Driver: counts and predicts each accepted beat, then offers the next one
  // (or idles) whenever the slot is free.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_critical_times(in_data);
        beats_accepted <= beats_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (task_beats_pending.size() > 0 &&
            $urandom_range(99) >= SEND_IDLE[idle_phase()]) begin
          in_data  <= task_beats_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest owed one, then
  // chooses out_ready for the next cycle.
  always @(posedge clk) begin
    tccp_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (crit_times_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: got idx=%0d crit=%0d err=%0b last=%0b", $time,
                   out_data.task_index, out_data.critical_time, out_data.graph_error,
                   out_data.last_result);
        end else begin
          want = crit_times_due.pop_front();
          if (out_data.task_index    !== want.task_index    ||
              out_data.critical_time !== want.critical_time ||
              out_data.graph_error   !== want.graph_error   ||
              out_data.last_result   !== want.last_result) begin
            mismatch_count++;
            $display("%0t: mismatch: exp idx=%0d crit=%0d err=%0b last=%0b",
                     $time, want.task_index, want.critical_time, want.graph_error,
                     want.last_result);
            $display("%0t:           got idx=%0d crit=%0d err=%0b last=%0b",
                     $time, out_data.task_index, out_data.critical_time,
                     out_data.graph_error, out_data.last_result);
          end
        end
      end
      // Once, with the sender never idling, sit on a pending result for a long
      // stretch so the block holds a finished graph and stalls its input.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && idle_phase() == 2 && out_valid) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= RECV_IDLE[idle_phase()]);
      end
    end
  end

  task automatic push_beat(input logic [TIME_W-1:0] t, input logic has,
                           input logic [3:0] idx, input logic last);
    tccp_in_t b;
    b.task_time       = t;
    b.has_successor   = has;
    b.successor_index = idx;
    b.last_task       = last;
    task_beats_pending.push_back(b);
  endtask

  // Times lean on the extremes so long chains come close to the top of the sum.
  function automatic logic [TIME_W-1:0] rand_task_time();
    case ($urandom_range(7))
      0:       return '0;
      1:       return {TIME_W{1'b1}};
      2:       return TIME_W'($urandom_range(255));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // One graph of n beats, last one marked. Beats past the store are random filler.
  task automatic add_graph(input int n, input graph_shape_e shape);
    int       held;
    int       odd_pos;
    tccp_in_t b;
    held    = (n > MAX_TASKS) ? MAX_TASKS : n;
    odd_pos = $urandom_range(held - 1);
    for (int i = 0; i < n; i++) begin
      b.task_time       = rand_task_time();
      b.last_task       = (i == n - 1);
      b.has_successor   = 1'b0;
      b.successor_index = 4'($urandom_range(15));
      if (shape == SHAPE_NOISE || i >= held) begin
        b.has_successor = 1'($urandom_range(1));
      end else if (shape == SHAPE_BAD_LINK && i == odd_pos) begin
        b.has_successor   = 1'b1;
        b.successor_index = 4'($urandom_range(15, held));
      end else if (shape == SHAPE_LOOP && i == odd_pos) begin
        b.has_successor   = 1'b1;
        b.successor_index = 4'($urandom_range(i));
      end else if (i < held - 1 && $urandom_range(3) != 0) begin
        b.has_successor   = 1'b1;
        b.successor_index = 4'($urandom_range(held - 1, i + 1));
      end
      task_beats_pending.push_back(b);
    end
  endtask

  initial begin
    int           pick;
    int           n;
    int           random_beats;
    graph_shape_e shape;

    // Directed graphs first.
    push_beat({TIME_W{1'b1}}, 1'b0, 4'hF, 1'b1);            // lone task at full time
    push_beat('0, 1'b1, 4'd1, 1'b0);                        // two-task chain
    push_beat({TIME_W{1'b1}}, 1'b0, 4'h0, 1'b1);
    push_beat(24'd5, 1'b1, 4'd0, 1'b1);                     // task linked to itself
    push_beat(24'd7, 1'b1, 4'd15, 1'b0);                    // link past the graph,
    push_beat(24'd1, 1'b0, 4'hA, 1'b1);                     // stray index ignored
    push_beat(24'd3, 1'b1, 4'd1, 1'b0);                     // two-task loop
    push_beat(24'd4, 1'b1, 4'd0, 1'b1);
    // Full store: 16 max-time tasks in one chain, 17th beat dropped but closes graph.
    for (int i = 0; i <= MAX_TASKS; i++)
      push_beat({TIME_W{1'b1}}, (i < MAX_TASKS - 1), 4'(i + 1), (i == MAX_TASKS));

    // Random graphs: mostly clean chains, the rest faulty or noise.
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      pick = $urandom_range(99);
      shape = (pick < 70) ? SHAPE_CHAINS : (pick < 80) ? SHAPE_BAD_LINK :
              (pick < 90) ? SHAPE_LOOP : SHAPE_NOISE;
      pick = $urandom_range(99);
      n = (pick < 75) ? $urandom_range(6, 1) :
          (pick < 93) ? $urandom_range(MAX_TASKS, 7) : $urandom_range(MAX_TASKS + 3, 17);
      if (shape == SHAPE_BAD_LINK && n > MAX_TASKS - 1) n = MAX_TASKS - 1;
      add_graph(n, shape);
      random_beats += n;
    end
    total_beats = task_beats_pending.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Every beat taken, every result back, then a quiet spell for strays.
    while (task_beats_pending.size() != 0 || in_valid) @(posedge clk);
    while (crit_times_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && crit_times_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/tccp_pkg.sv
rtl/tccp_sat_add.sv
rtl/task_chain_critical_path.sv
tb/sv/task_chain_critical_path_tb.sv
